// ===== rtl/gqt_pkg.sv =====
// Shared types, token codes and keyword tables of the graph query tokenizer.
package gqt_pkg;

  localparam int unsigned OFFSET_WIDTH_DEF = 16;
  localparam int unsigned MID_DEPTH        = 2;
  localparam int unsigned RBUF_DEPTH       = 4;
  localparam int unsigned MAX_RESULTS      = 3;
  localparam int unsigned KW_COUNT         = 6;

  localparam logic [15:0] FIRST_LINE_RST = 16'd1;

  // Token kinds.
  localparam logic [4:0] K_ERR        = 5'd0;
  localparam logic [4:0] K_LPAREN     = 5'd0;
  localparam logic [4:0] K_RPAREN     = 5'd1;
  localparam logic [4:0] K_LBRACK     = 5'd2;
  localparam logic [4:0] K_RBRACK     = 5'd3;
  localparam logic [4:0] K_COMMA      = 5'd4;
  localparam logic [4:0] K_COLON      = 5'd5;
  localparam logic [4:0] K_DOT        = 5'd6;
  localparam logic [4:0] K_SEMI       = 5'd7;
  localparam logic [4:0] K_EQUAL      = 5'd8;
  localparam logic [4:0] K_STAR       = 5'd9;
  localparam logic [4:0] K_PLUS       = 5'd10;
  localparam logic [4:0] K_LEFT_ARROW = 5'd11;
  localparam logic [4:0] K_ARROW_STAR = 5'd12;
  localparam logic [4:0] K_ARROW_PLUS = 5'd13;
  localparam logic [4:0] K_ARROW      = 5'd14;
  localparam logic [4:0] K_DASH       = 5'd15;
  localparam logic [4:0] K_INT        = 5'd16;
  localparam logic [4:0] K_IDENT      = 5'd17;
  localparam logic [4:0] K_KW0        = 5'd18;
  localparam logic [4:0] K_END        = 5'd24;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
  localparam logic [1:0] ERR_LT       = 2'd2;

  localparam logic [7:0] CH_LT = 8'h3C;

  // Keyword text, first character in the top byte, upper case.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    {"MATCH", 24'd0},
    {"WHERE", 24'd0},
    {"COLUMNS", 8'd0},
    {"IN", 48'd0},
    {"ANY", 40'd0},
    "SHORTEST"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd5, 4'd5, 4'd7, 4'd2, 4'd3, 4'd8};

  typedef enum logic [3:0] {
    CLS_SKIP,
    CLS_NL,
    CLS_PUNCT,
    CLS_LT,
    CLS_DASH,
    CLS_GT,
    CLS_DIGIT,
    CLS_WORD,
    CLS_OTHER
  } cls_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_only;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic [15:0] line_number;
    logic [1:0]  error_code;
    logic [7:0]  bad_char;
    logic        last_result;
  } out_item_t;

  // A classified byte as it travels from the front to the scanner.
  typedef struct packed {
    logic [7:0] char_byte;
    logic [7:0] upper;
    cls_e       cls;
    logic [4:0] punct_kind;
    logic       end_only;
    logic       last_byte;
  } cls_t;

  // The results that one item produces, written into the result buffer at once.
  typedef struct packed {
    logic                 wr;
    logic [1:0]           cnt;
    out_item_t [MAX_RESULTS-1:0] item;
  } res_grp_t;

  function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] idx);
    logic [5:0] lsb;
    lsb = {3'd7 - idx, 3'b000};
    return KW_TEXT[k][lsb +: 8];
  endfunction

endpackage

// ===== rtl/gqt_front.sv =====
// Front end: classifies each incoming byte for the scanner.
module gqt_front import gqt_pkg::*; (
  input  in_item_t in_item_i,
  output cls_t     cls_o
);

  logic [7:0] c;

  assign c = in_item_i.char_byte;

  always_comb begin
    cls_o            = '0;
    cls_o.char_byte  = c;
    cls_o.end_only   = in_item_i.end_only;
    cls_o.last_byte  = in_item_i.last_byte;
    cls_o.upper      = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    cls_o.punct_kind = K_LPAREN;
    cls_o.cls        = CLS_OTHER;
    case (c)
      " ", 8'h09, 8'h0D: cls_o.cls = CLS_SKIP;
      8'h0A:             cls_o.cls = CLS_NL;
      "<":               cls_o.cls = CLS_LT;
      "-":               cls_o.cls = CLS_DASH;
      ">":               cls_o.cls = CLS_GT;
      "(": begin cls_o.cls = CLS_PUNCT; cls_o.punct_kind = K_LPAREN; end
      ")": begin cls_o.cls = CLS_PUNCT; cls_o.punct_kind = K_RPAREN; end
      "[": begin cls_o.cls = CLS_PUNCT; cls_o.punct_kind = K_LBRACK; end
      "]": begin cls_o.cls = CLS_PUNCT; cls_o.punct_kind = K_RBRACK; end
      ",": begin cls_o.cls = CLS_PUNCT; cls_o.punct_kind = K_COMMA; end
      ":": begin cls_o.cls = CLS_PUNCT; cls_o.punct_kind = K_COLON; end
      ".": begin cls_o.cls = CLS_PUNCT; cls_o.punct_kind = K_DOT; end
      ";": begin cls_o.cls = CLS_PUNCT; cls_o.punct_kind = K_SEMI; end
      "=": begin cls_o.cls = CLS_PUNCT; cls_o.punct_kind = K_EQUAL; end
      "*": begin cls_o.cls = CLS_PUNCT; cls_o.punct_kind = K_STAR; end
      "+": begin cls_o.cls = CLS_PUNCT; cls_o.punct_kind = K_PLUS; end
      default: begin
        if (c >= "0" && c <= "9") begin
          cls_o.cls = CLS_DIGIT;
        end else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_") begin
          cls_o.cls = CLS_WORD;
        end
      end
    endcase
  end

endmodule

// ===== rtl/gqt_fifo.sv =====
// Small register queue between the front end and the scanner.
module gqt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
    if (do_push) begin
      wr_d = (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/gqt_scan.sv =====
// Back end scanner: token state machine, keyword narrowing and result forming.
module gqt_scan import gqt_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        avail_i,
  input  cls_t        cls_i,
  input  logic        room_i,
  output logic        take_o,
  output res_grp_t    grp_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_LT,
    M_DASH,
    M_ARROW,
    M_NUM,
    M_WORD,
    M_DEAD
  } mode_e;

  typedef logic [OFFSET_WIDTH-1:0] ofs_t;

  mode_e       mode_q, mode_d;
  ofs_t        pos_q, pos_d, ts_q, ts_d;
  logic [15:0] line_q, line_d, first_q;
  logic [5:0]  cand_q, cand_d;
  logic [3:0]  wlen_q, wlen_d;

  function automatic logic [15:0] sat16(input ofs_t v);
    if (v > OFFSET_WIDTH'(17'h0FFFF)) begin
      return 16'hFFFF;
    end
    return 16'(v);
  endfunction

  function automatic out_item_t mk(input logic [4:0] kind, input ofs_t start, input ofs_t len,
                                   input logic [15:0] line, input logic [1:0] err,
                                   input logic [7:0] bad, input logic last);
    out_item_t r;
    r.token_kind   = kind;
    r.start_offset = sat16(start);
    r.token_length = sat16(len);
    r.line_number  = line;
    r.error_code   = err;
    r.bad_char     = bad;
    r.last_result  = last;
    return r;
  endfunction

  // One character of a word: drop every keyword that no longer matches.
  function automatic logic [9:0] word_step(input logic [5:0] cand, input logic [3:0] wlen,
                                           input logic [7:0] up);
    logic [5:0] c;
    logic [3:0] w;
    c = cand;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (wlen >= KW_LEN[k] || kw_char(k, wlen[2:0]) != up) begin
        c[k] = 1'b0;
      end
    end
    w = (wlen != 4'd15) ? wlen + 4'd1 : wlen;
    return {c, w};
  endfunction

  function automatic logic [4:0] word_kind(input logic [5:0] cand, input logic [3:0] wlen);
    logic [4:0] kind;
    kind = K_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand[k] && wlen == KW_LEN[k]) begin
        kind = K_KW0 + 5'(k);
      end
    end
    return kind;
  endfunction

  // Pending token at the end of a run; a lone '<' becomes an error.
  function automatic out_item_t flush_tok(input mode_e mode, input ofs_t ts, input ofs_t pos,
                                          input logic [5:0] cand, input logic [3:0] wlen,
                                          input logic [15:0] line);
    out_item_t r;
    ofs_t      len;
    len = pos - ts;
    case (mode)
      M_LT:    r = mk(K_ERR, ts, '0, line, ERR_LT, CH_LT, 1'b1);
      M_DASH:  r = mk(K_DASH, ts, len, line, ERR_NONE, 8'd0, 1'b0);
      M_ARROW: r = mk(K_ARROW, ts, len, line, ERR_NONE, 8'd0, 1'b0);
      M_NUM:   r = mk(K_INT, ts, len, line, ERR_NONE, 8'd0, 1'b0);
      default: r = mk(word_kind(cand, wlen), ts, len, line, ERR_NONE, 8'd0, 1'b0);
    endcase
    return r;
  endfunction

  assign take_o = avail_i && room_i;

  always_comb begin
    logic [1:0] n;
    ofs_t       nxt;
    logic       took, fin, restart;
    out_item_t  tok;
    logic [9:0] ws;

    mode_d  = mode_q;
    pos_d   = pos_q;
    ts_d    = ts_q;
    line_d  = line_q;
    cand_d  = cand_q;
    wlen_d  = wlen_q;
    grp_o   = '0;
    n       = 2'd0;
    nxt     = pos_q;
    took    = 1'b0;
    fin     = 1'b0;
    restart = 1'b0;
    tok     = '0;
    ws      = '0;

    if (take_o) begin
      if (cls_i.end_only) begin
        fin = 1'b1;
      end else if (mode_d == M_DEAD) begin
        restart = cls_i.last_byte;
      end else begin
        nxt = (pos_d != '1) ? pos_d + ofs_t'(1) : pos_d;
        unique case (mode_d)
          M_LT: begin
            took = 1'b1;
            if (cls_i.cls == CLS_DASH) begin
              tok    = mk(K_LEFT_ARROW, ts_d, nxt - ts_d, line_d, ERR_NONE, 8'd0, 1'b0);
              mode_d = M_IDLE;
            end else begin
              tok    = mk(K_ERR, ts_d, '0, line_d, ERR_LT, CH_LT, 1'b1);
              mode_d = M_DEAD;
            end
            grp_o.item[n] = tok;
            n = n + 2'd1;
          end
          M_DASH: begin
            if (cls_i.cls == CLS_GT) begin
              mode_d = M_ARROW;
              took   = 1'b1;
            end
          end
          M_ARROW: begin
            if (cls_i.cls == CLS_PUNCT &&
                (cls_i.punct_kind == K_STAR || cls_i.punct_kind == K_PLUS)) begin
              tok = mk((cls_i.punct_kind == K_STAR) ? K_ARROW_STAR : K_ARROW_PLUS,
                       ts_d, nxt - ts_d, line_d, ERR_NONE, 8'd0, 1'b0);
              grp_o.item[n] = tok;
              n      = n + 2'd1;
              mode_d = M_IDLE;
              took   = 1'b1;
            end
          end
          M_NUM: begin
            took = (cls_i.cls == CLS_DIGIT);
          end
          M_WORD: begin
            if (cls_i.cls == CLS_DIGIT || cls_i.cls == CLS_WORD) begin
              ws     = word_step(cand_d, wlen_d, cls_i.upper);
              cand_d = ws[9:4];
              wlen_d = ws[3:0];
              took   = 1'b1;
            end
          end
          default: ;
        endcase

        // A run that this byte does not continue is closed first.
        if (!took && (mode_d inside {M_DASH, M_ARROW, M_NUM, M_WORD})) begin
          grp_o.item[n] = flush_tok(mode_d, ts_d, pos_d, cand_d, wlen_d, line_d);
          n      = n + 2'd1;
          mode_d = M_IDLE;
        end

        if (!took && mode_d == M_IDLE) begin
          case (cls_i.cls)
            CLS_SKIP: ;
            CLS_NL: begin
              if (line_d != 16'hFFFF) begin
                line_d = line_d + 16'd1;
              end
            end
            CLS_PUNCT: begin
              grp_o.item[n] = mk(cls_i.punct_kind, pos_d, ofs_t'(1), line_d, ERR_NONE,
                                 8'd0, 1'b0);
              n = n + 2'd1;
            end
            CLS_LT: begin
              ts_d   = pos_d;
              mode_d = M_LT;
            end
            CLS_DASH: begin
              ts_d   = pos_d;
              mode_d = M_DASH;
            end
            CLS_DIGIT: begin
              ts_d   = pos_d;
              mode_d = M_NUM;
            end
            CLS_WORD: begin
              ts_d   = pos_d;
              mode_d = M_WORD;
              ws     = word_step(6'h3F, 4'd0, cls_i.upper);
              cand_d = ws[9:4];
              wlen_d = ws[3:0];
            end
            default: begin
              grp_o.item[n] = mk(K_ERR, pos_d, '0, line_d, ERR_BAD_CHAR, cls_i.char_byte,
                                 1'b1);
              n      = n + 2'd1;
              mode_d = M_DEAD;
            end
          endcase
        end
        pos_d = nxt;
        fin   = cls_i.last_byte;
      end

      // End of source: close the pending run, then the end token.
      if (fin) begin
        restart = 1'b1;
        if (mode_d != M_DEAD && mode_d != M_IDLE) begin
          grp_o.item[n] = flush_tok(mode_d, ts_d, pos_d, cand_d, wlen_d, line_d);
          n      = n + 2'd1;
          mode_d = (mode_d == M_LT) ? M_DEAD : M_IDLE;
        end
        if (mode_d != M_DEAD && n != 2'd3) begin
          grp_o.item[n] = mk(K_END, pos_d, '0, line_d, ERR_NONE, 8'd0, 1'b1);
          n = n + 2'd1;
        end
      end

      if (restart) begin
        mode_d = M_IDLE;
        pos_d  = '0;
        ts_d   = '0;
        line_d = first_q;
        cand_d = 6'h3F;
        wlen_d = 4'd0;
      end
    end

    grp_o.wr  = take_o;
    grp_o.cnt = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      pos_q   <= '0;
      ts_q    <= '0;
      line_q  <= FIRST_LINE_RST;
      cand_q  <= 6'h3F;
      wlen_q  <= 4'd0;
      first_q <= FIRST_LINE_RST;
    end else begin
      mode_q <= mode_d;
      pos_q  <= pos_d;
      ts_q   <= ts_d;
      cand_q <= cand_d;
      wlen_q <= wlen_d;
      // A register write before the source has begun also sets the current line.
      line_q <= (cfg_we_i && pos_q == '0 && mode_q == M_IDLE) ? cfg_wdata_i : line_d;
      if (cfg_we_i) begin
        first_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ===== rtl/gqt_rbuf.sv =====
// Result buffer: takes up to three results per cycle, hands out one per cycle while pop is high.
module gqt_rbuf import gqt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_grp_t  grp_i,
  output logic      room_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(RBUF_DEPTH);
  localparam int unsigned CW = $clog2(RBUF_DEPTH + 1);

  out_item_t     mem_q [RBUF_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q, cnt_left;
  logic          do_pop;

  assign empty_o    = (cnt_q == '0);
  assign do_pop     = pop_i && !empty_o;
  assign out_item_o = mem_q[rd_q];
  assign cnt_left   = cnt_q - CW'(do_pop);
  // Room for a full group of results once this cycle's pop is counted.
  assign room_o     = (cnt_left <= CW'(RBUF_DEPTH - MAX_RESULTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (grp_i.wr) begin
        wr_q <= wr_q + AW'(grp_i.cnt);
      end
      if (do_pop) begin
        rd_q <= rd_q + AW'(1);
      end
      cnt_q <= cnt_left + (grp_i.wr ? CW'(grp_i.cnt) : CW'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    logic [AW-1:0] off;
    for (int e = 0; e < RBUF_DEPTH; e++) begin
      off = AW'(e) - wr_q;
      if (grp_i.wr && off < AW'(grp_i.cnt)) begin
        mem_q[e] <= grp_i.item[2'(off)];
      end
    end
  end

endmodule

// ===== rtl/graph_query_tokenizer_top.sv =====
// Top level of the graph query tokenizer: front end, queue, scanner, result buffer.
//
// Query text enters one byte per item on the input queue port: an item is taken
// at a clock edge with push high and full low. An item either carries a byte
// (with last_byte marking the final byte of a source) or, with end_only set,
// only closes the source. Tokens leave on the result queue port: the oldest
// token sits on out_item_o while empty is low and is taken when pop is high.
// An item passes the queue and then the scanner, which writes its tokens into the result buffer.
// The block takes one item per cycle as long as the four-entry result buffer,
// once this cycle's pop is counted, has room for three more tokens; an item
// that yields several tokens (a closed run plus a punctuation mark plus the end
// token) fills the buffer faster than pop drains it and can hold the scanner.
// When the receiver stalls, the result buffer fills, the scanner stops, the
// two-entry queue behind the front end fills, and full rises.
// After reset no token is pending, offsets start at zero and the line count
// starts at 1. A write on cfg_we_i sets the first line number; written while
// the block is idle at the start of a source, it also sets the current line.
// After an error result, bytes are dropped until the item that ends the source.
module graph_query_tokenizer_top import gqt_pkg::*; #(
  parameter int unsigned OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  in_item_t    in_item_i,
  output logic        empty,
  input  logic        pop,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  cls_t     cls_in, cls_out;
  logic     mid_empty;
  logic     take;
  logic     room;
  res_grp_t grp;

  // Byte classification ahead of the queue.
  gqt_front u_front (
    .in_item_i (in_item_i),
    .cls_o     (cls_in)
  );

  // Short queue that lets input and scanner stall independently.
  gqt_fifo #(
    .WIDTH ($bits(cls_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (cls_in),
    .full_o  (full),
    .pop_i   (take),
    .rdata_o (cls_out),
    .empty_o (mid_empty)
  );

  // Scanner: consumes one classified item per cycle when the queue is not empty and results have room.
  gqt_scan #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (!mid_empty),
    .cls_i       (cls_out),
    .room_i      (room),
    .take_o      (take),
    .grp_o       (grp),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Output queue of finished tokens.
  gqt_rbuf u_rbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .grp_i      (grp),
    .room_o     (room),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule
